FILE: rtl/iems_pkg.sv
// iems_pkg: constants, register indexes and unit request types for the
// isotope envelope match scorer. No dependencies.
package iems_pkg;

    localparam int MAX_PEAKS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_FRAC = 8;
    localparam int ADDR_W    = $clog2(MAX_PEAKS);
    localparam int CNT_W     = $clog2(MAX_PEAKS + 1);
    localparam int PEAK_W    = 32 * 4 + 1;
    localparam int SCORE_W   = 48;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_EN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_K    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_BEG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_END  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_SCL  = 3'd7;

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] num;
        logic [47:0] den;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } unit_rsp_t;

endpackage

FILE: rtl/iems_if.sv
// iems_peak_if and iems_score_if: valid/ready channels for peak beats and
// score beats. No dependencies.
interface iems_peak_if;
    logic        valid;
    logic        ready;
    logic [31:0] theo_mz;
    logic [31:0] theo_level;
    logic [31:0] real_mz;
    logic [31:0] obs_level;
    logic        real_present;
    logic        last_peak;

    modport source (output valid, theo_mz, theo_level, real_mz, obs_level,
                    real_present, last_peak, input ready);
    modport sink (input valid, theo_mz, theo_level, real_mz, obs_level,
                  real_present, last_peak, output ready);
endinterface

interface iems_score_if;
    logic               valid;
    logic               ready;
    logic [47:0]        match_score;
    logic signed [8:0]  chosen_shift;
    logic [11:0]        chosen_ratio;

    modport source (output valid, match_score, chosen_shift, chosen_ratio, input ready);
    modport sink (input valid, match_score, chosen_shift, chosen_ratio, output ready);
endinterface

FILE: rtl/iems_ram.sv
// iems_ram: generic one-write one-read memory with registered read data.
// No dependencies.
module iems_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/iems_unit.sv
// iems_unit: shared bit-serial divider (64 by 48 bits, one quotient bit a
// cycle) and integer square root (two radicand bits a cycle). Depends on iems_pkg.
module iems_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  iems_pkg::unit_req_t req,
    output iems_pkg::unit_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;

    logic [48:0] rem_sh;
    logic [48:0] rem_sub;
    logic        div_ge;
    logic [63:0] sq_sum;
    logic        sq_ge;

    assign rem_sh  = {rem_reg, acc_reg[63]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign sq_sum  = res_reg + bit_reg;
    assign sq_ge   = acc_reg >= sq_sum;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (busy_reg)
        begin
            if (op_reg == iems_pkg::OP_DIV)
            begin
                rem_next = div_ge ? rem_sub[47:0] : rem_sh[47:0];
                acc_next = {acc_reg[62:0], div_ge};
            end
            else
            begin
                if (sq_ge)
                begin
                    acc_next = acc_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = (req.op == iems_pkg::OP_DIV) ? 7'd63 : 7'd31;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == iems_pkg::OP_DIV) ? acc_reg : res_reg;

endmodule

FILE: rtl/isotope_envelope_match_scorer_top.sv
// isotope_envelope_match_scorer_top: peak store, search sequencer and score
// accumulation. Depends on iems_pkg, iems_if, iems_ram and iems_unit.
//
// Peaks are taken one a cycle into a 32-entry store; the beat flagged
// last_peak ends the envelope and the block then stops taking peaks until
// the score beat has been handed to the output register. Scoring makes one
// pass over the stored peaks for each shift step (2k+1 passes when the shift
// search is on), one for each ratio step in range, and one final pass. An
// absent peak is only read and skipped; a present peak takes as long as
// the shared divide/square-root unit needs, which yields one quotient bit
// or one root bit a cycle and does up to five operations per peak. The
// score beat waits in its register while the next envelope loads.
module isotope_envelope_match_scorer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [iems_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iems_pkg::CFG_W-1:0]           cfg_data,
    iems_peak_if.sink                            peak_in,
    iems_score_if.source                         score_out
);

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_RINIT = 5'd2;
    localparam logic [4:0] S_SHAMT = 5'd3;
    localparam logic [4:0] S_RD    = 5'd4;
    localparam logic [4:0] S_CAP   = 5'd5;
    localparam logic [4:0] S_MULTR = 5'd6;
    localparam logic [4:0] S_MULDN = 5'd7;
    localparam logic [4:0] S_MZ    = 5'd8;
    localparam logic [4:0] S_MZW   = 5'd9;
    localparam logic [4:0] S_NDIV  = 5'd10;
    localparam logic [4:0] S_NDW   = 5'd11;
    localparam logic [4:0] S_NSW   = 5'd12;
    localparam logic [4:0] S_INT   = 5'd13;
    localparam logic [4:0] S_QW    = 5'd14;
    localparam logic [4:0] S_LIN   = 5'd15;
    localparam logic [4:0] S_AW    = 5'd16;
    localparam logic [4:0] S_MA    = 5'd17;
    localparam logic [4:0] S_ACC   = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;
    localparam logic [4:0] S_EMIT  = 5'd20;

    localparam logic [1:0] PH_SH  = 2'd0;
    localparam logic [1:0] PH_RA  = 2'd1;
    localparam logic [1:0] PH_FIN = 2'd2;

    localparam int F = iems_pkg::FRAC_BITS;
    localparam int CW = iems_pkg::CNT_W;
    localparam logic [17:0] LIN_ONE = 18'(3) << F;
    localparam logic [17:0] Q_SAT   = 18'(2) << F;

    // configuration
    logic        shift_en_reg, ratio_en_reg;
    logic [23:0] tol_reg;
    logic [7:0]  shift_k_reg;
    logic [15:0] shift_step_reg;
    logic [11:0] ratio_beg_reg, ratio_end_reg, ratio_scl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_en_reg   <= 1'b1;
            ratio_en_reg   <= 1'b1;
            tol_reg        <= 24'd1311;
            shift_k_reg    <= 8'd2;
            shift_step_reg <= 16'd655;
            ratio_beg_reg  <= 12'd50;
            ratio_end_reg  <= 12'd200;
            ratio_scl_reg  <= 12'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iems_pkg::REG_SHIFT_EN:   shift_en_reg   <= cfg_data[0];
                iems_pkg::REG_RATIO_EN:   ratio_en_reg   <= cfg_data[0];
                iems_pkg::REG_TOLERANCE:  tol_reg        <= cfg_data[23:0];
                iems_pkg::REG_SHIFT_K:    shift_k_reg    <= cfg_data[7:0];
                iems_pkg::REG_SHIFT_STEP: shift_step_reg <= cfg_data[15:0];
                iems_pkg::REG_RATIO_BEG:  ratio_beg_reg  <= cfg_data[11:0];
                iems_pkg::REG_RATIO_END:  ratio_end_reg  <= cfg_data[11:0];
                iems_pkg::REG_RATIO_SCL:  ratio_scl_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // control registers
    logic [4:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                first_reg, first_next;
    logic                out_valid_reg, out_valid_next;

    // datapath registers
    logic [11:0]         scale_reg, scale_next;
    logic signed [8:0]   cur_s_reg, cur_s_next;
    logic signed [8:0]   best_s_reg, best_s_next;
    logic [11:0]         cur_r_reg, cur_r_next;
    logic [11:0]         best_r_reg, best_r_next;
    logic [47:0]         best_reg, best_next;
    logic [47:0]         sum_reg, sum_next;
    logic signed [25:0]  shamt_reg, shamt_next;
    logic [31:0]         tm_reg, ti_reg, rm_reg, ri_reg;
    logic [43:0]         tr_reg, tr_next;
    logic [43:0]         den_reg, den_next;
    logic [33:0]         dist_reg, dist_next;
    logic [16:0]         m_reg, m_next;
    logic [16:0]         a_reg, a_next;
    logic [29:0]         n_reg, n_next;
    logic [17:0]         q_reg, q_next;
    logic [33:0]         ma_reg, ma_next;
    logic [47:0]         out_score_reg, out_score_next;
    logic signed [8:0]   out_shift_reg, out_shift_next;
    logic [11:0]         out_ratio_reg, out_ratio_next;

    iems_pkg::unit_req_t ureq;
    iems_pkg::unit_rsp_t ursp;

    iems_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .rsp   (ursp)
    );

    logic                        ram_we;
    logic [iems_pkg::PEAK_W-1:0] ram_wdata, ram_rdata;

    assign ram_we    = peak_in.valid && peak_in.ready && (count_reg < CW'(iems_pkg::MAX_PEAKS));
    assign ram_wdata = {peak_in.theo_mz, peak_in.theo_level, peak_in.real_mz,
                        peak_in.obs_level, peak_in.real_present};

    iems_ram #(
        .WIDTH (iems_pkg::PEAK_W),
        .DEPTH (iems_pkg::MAX_PEAKS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[iems_pkg::ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[iems_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign peak_in.ready = (state_reg == S_LOAD);

    logic signed [8:0]  k_s;
    logic signed [34:0] diff;
    logic [47:0]        prod;
    logic [48:0]        sum_wide;
    logic               better;
    logic [18:0]        q2;

    assign k_s      = $signed({1'b0, shift_k_reg});
    assign diff     = $signed({3'b0, tm_reg}) + 35'(shamt_reg) - $signed({3'b0, rm_reg});
    assign prod     = ma_reg[33:16] * n_reg;
    assign sum_wide = {1'b0, sum_reg} + 49'(prod >> iems_pkg::NORM_FRAC);
    assign better   = first_reg || (sum_reg > best_reg);
    assign q2       = {q_reg, 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        scale_next     = scale_reg;
        cur_s_next     = cur_s_reg;
        best_s_next    = best_s_reg;
        cur_r_next     = cur_r_reg;
        best_r_next    = best_r_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        shamt_next     = shamt_reg;
        tr_next        = tr_reg;
        den_next       = den_reg;
        dist_next      = dist_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        q_next         = q_reg;
        ma_next        = ma_reg;
        out_score_next = out_score_reg;
        out_shift_next = out_shift_reg;
        out_ratio_next = out_ratio_reg;
        ureq.start     = 1'b0;
        ureq.op        = iems_pkg::OP_DIV;
        ureq.num       = {20'd0, tr_reg} << F;
        ureq.den       = {36'd0, scale_reg};

        if (score_out.valid && score_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (peak_in.valid)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (peak_in.last_peak)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                scale_next  = (ratio_scl_reg == 12'd0) ? 12'd1 : ratio_scl_reg;
                first_next  = 1'b1;
                best_s_next = '0;
                if (shift_en_reg)
                begin
                    phase_next = PH_SH;
                    cur_s_next = -k_s;
                    cur_r_next = (ratio_scl_reg == 12'd0) ? 12'd1 : ratio_scl_reg;
                    state_next = S_SHAMT;
                end
                else
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cur_s_next = best_s_reg;
                first_next = 1'b1;
                state_next = S_SHAMT;
                if (!ratio_en_reg)
                begin
                    best_r_next = scale_reg;
                    cur_r_next  = scale_reg;
                    phase_next  = PH_FIN;
                end
                else if (ratio_beg_reg > ratio_end_reg)
                begin
                    best_r_next = '0;
                    cur_r_next  = '0;
                    phase_next  = PH_FIN;
                end
                else
                begin
                    cur_r_next = ratio_beg_reg;
                    phase_next = PH_RA;
                end
            end
            S_SHAMT:
            begin
                shamt_next = 26'(cur_s_reg * $signed({1'b0, shift_step_reg}));
                idx_next   = '0;
                sum_next   = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = (idx_reg == count_reg) ? S_DONE : S_CAP;
            end
            S_CAP:
            begin
                if (!ram_rdata[0])
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_MULTR;
                end
            end
            S_MULTR:
            begin
                tr_next    = ti_reg * cur_r_reg;
                dist_next  = diff[34] ? 34'(-diff) : diff[33:0];
                state_next = S_MULDN;
            end
            S_MULDN:
            begin
                den_next   = scale_reg * ri_reg;
                state_next = S_MZ;
            end
            S_MZ:
            begin
                if (tol_reg == 24'd0 || dist_reg >= {10'd0, tol_reg})
                begin
                    m_next     = '0;
                    state_next = S_NDIV;
                end
                else
                begin
                    ureq.start = 1'b1;
                    ureq.num   = {40'd0, tol_reg - dist_reg[23:0]} << F;
                    ureq.den   = {24'd0, tol_reg};
                    state_next = S_MZW;
                end
            end
            S_MZW:
            begin
                if (ursp.done)
                begin
                    m_next     = ursp.result[16:0];
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                ureq.start = 1'b1;
                state_next = S_NDW;
            end
            S_NDW:
            begin
                if (ursp.done)
                begin
                    ureq.start = 1'b1;
                    ureq.op    = iems_pkg::OP_SQRT;
                    ureq.num   = ursp.result;
                    state_next = S_NSW;
                end
            end
            S_NSW:
            begin
                if (ursp.done)
                begin
                    n_next     = ursp.result[29:0];
                    state_next = S_INT;
                end
            end
            S_INT:
            begin
                if (ri_reg == 32'd0)
                begin
                    a_next     = '0;
                    state_next = S_MA;
                end
                else if ({1'b0, tr_reg} >= {den_reg, 1'b0})
                begin
                    q_next     = Q_SAT;
                    state_next = S_LIN;
                end
                else
                begin
                    ureq.start = 1'b1;
                    ureq.den   = {4'd0, den_reg};
                    state_next = S_QW;
                end
            end
            S_QW:
            begin
                if (ursp.done)
                begin
                    q_next = ursp.result[17:0];
                    if (tr_reg <= den_reg)
                    begin
                        ureq.start = 1'b1;
                        ureq.op    = iems_pkg::OP_SQRT;
                        ureq.num   = {46'd0, ursp.result[17:0]} << F;
                        state_next = S_AW;
                    end
                    else
                    begin
                        state_next = S_LIN;
                    end
                end
            end
            S_LIN:
            begin
                a_next     = ({1'b0, q2[17:0]} >= {1'b0, LIN_ONE} || q2[18]) ? 17'd0
                             : 17'(LIN_ONE - q2[17:0]);
                state_next = S_MA;
            end
            S_AW:
            begin
                if (ursp.done)
                begin
                    a_next     = ursp.result[16:0];
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                ma_next    = m_reg * a_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next   = sum_wide[48] ? {48{1'b1}} : sum_wide[47:0];
                idx_next   = idx_reg + CW'(1);
                state_next = S_RD;
            end
            S_DONE:
            begin
                case (phase_reg)
                    PH_SH:
                    begin
                        if (better)
                        begin
                            best_next   = sum_reg;
                            best_s_next = cur_s_reg;
                        end
                        first_next = 1'b0;
                        if (cur_s_reg == k_s)
                        begin
                            state_next = S_RINIT;
                        end
                        else
                        begin
                            cur_s_next = cur_s_reg + 9'sd1;
                            state_next = S_SHAMT;
                        end
                    end
                    PH_RA:
                    begin
                        first_next = 1'b0;
                        if (better)
                        begin
                            best_next   = sum_reg;
                            best_r_next = cur_r_reg;
                        end
                        if (cur_r_reg == ratio_end_reg)
                        begin
                            cur_r_next = better ? cur_r_reg : best_r_reg;
                            phase_next = PH_FIN;
                        end
                        else
                        begin
                            cur_r_next = cur_r_reg + 12'd1;
                        end
                        state_next = S_SHAMT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (!out_valid_reg || score_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_score_next = sum_reg;
                    out_shift_next = best_s_reg;
                    out_ratio_next = best_r_reg;
                    count_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            phase_reg     <= PH_SH;
            count_reg     <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg     <= scale_next;
        cur_s_reg     <= cur_s_next;
        best_s_reg    <= best_s_next;
        cur_r_reg     <= cur_r_next;
        best_r_reg    <= best_r_next;
        best_reg      <= best_next;
        sum_reg       <= sum_next;
        shamt_reg     <= shamt_next;
        tr_reg        <= tr_next;
        den_reg       <= den_next;
        dist_reg      <= dist_next;
        m_reg         <= m_next;
        a_reg         <= a_next;
        n_reg         <= n_next;
        q_reg         <= q_next;
        ma_reg        <= ma_next;
        out_score_reg <= out_score_next;
        out_shift_reg <= out_shift_next;
        out_ratio_reg <= out_ratio_next;
        if (state_reg == S_CAP)
        begin
            {tm_reg, ti_reg, rm_reg, ri_reg} <= ram_rdata[iems_pkg::PEAK_W-1:1];
        end
    end

    assign score_out.valid        = out_valid_reg;
    assign score_out.match_score  = out_score_reg;
    assign score_out.chosen_shift = out_shift_reg;
    assign score_out.chosen_ratio = out_ratio_reg;

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for isotope_envelope_match_scorer_top, with a
// peak driver, a score monitor and a bit-exact envelope score predictor.
// Depends on iems_pkg, iems_if and the scorer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [31:0] theo_mz;
        bit [31:0] theo_lvl;
        bit [31:0] real_mz;
        bit [31:0] obs_lvl;
        bit        present;
        bit        last;
    } peak_beat_t;

    typedef struct {
        bit [47:0] score;
        bit [8:0]  shift;
        bit [11:0] ratio;
    } score_beat_t;

    localparam longint unsigned SCORE_SAT = (64'd1 << 48) - 64'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [iems_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [iems_pkg::CFG_W-1:0] cfg_data = '0;

    iems_peak_if peak_in();
    iems_score_if score_out();

    isotope_envelope_match_scorer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .peak_in   (peak_in.sink),
        .score_out (score_out.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    peak_beat_t  pending_peaks[$];
    score_beat_t expected_scores[$];
    int          mismatch_count = 0;
    bit          burst = 1'b0;
    int          hold_ask = 0;

    // register mirror
    bit        sh_en = 1'b1;
    bit        ra_en = 1'b1;
    bit [23:0] tol = 24'd1311;
    bit [7:0]  shift_k = 8'd2;
    bit [15:0] shift_step = 16'd655;
    bit [11:0] ratio_beg = 12'd50;
    bit [11:0] ratio_end = 12'd200;
    bit [11:0] ratio_scl = 12'd100;

    // envelope store mirror
    bit [31:0] st_theo_mz[iems_pkg::MAX_PEAKS];
    bit [31:0] st_theo_lvl[iems_pkg::MAX_PEAKS];
    bit [31:0] st_real_mz[iems_pkg::MAX_PEAKS];
    bit [31:0] st_obs_lvl[iems_pkg::MAX_PEAKS];
    bit        st_present[iems_pkg::MAX_PEAKS];
    int        st_count = 0;

    function automatic longint unsigned isqrt_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned envelope_sum(longint shift_amt, longint unsigned r,
                                                     longint unsigned scale);
        longint unsigned sum, m, a, n, num, den, q, err_abs, t, tl;
        longint d;
        sum = 0;
        tl = 64'(tol);
        for (int i = 0; i < st_count; i++)
        begin
            if (!st_present[i])
                continue;
            d = longint'(st_theo_mz[i]) + shift_amt - longint'(st_real_mz[i]);
            err_abs = (d < 0) ? -d : d;
            if (tl == 0 || err_abs >= tl)
                m = 0;
            else
                m = ((tl - err_abs) << iems_pkg::FRAC_BITS) / tl;
            t = 64'(st_theo_lvl[i]);
            num = t * r;
            den = scale * 64'(st_obs_lvl[i]);
            if (st_obs_lvl[i] == 0)
                a = 0;
            else
            begin
                q = (num >= 2 * den) ? (64'd2 << iems_pkg::FRAC_BITS)
                                     : ((num << iems_pkg::FRAC_BITS) / den);
                if (num <= den)
                    a = isqrt_floor(q << iems_pkg::FRAC_BITS);
                else
                    a = (2 * q >= (64'd3 << iems_pkg::FRAC_BITS)) ? 0
                        : (64'd3 << iems_pkg::FRAC_BITS) - 2 * q;
            end
            n = isqrt_floor((num << 16) / scale);
            sum = sum + ((((m * a) >> iems_pkg::FRAC_BITS) * n) >> iems_pkg::NORM_FRAC);
            if (sum > SCORE_SAT)
                sum = SCORE_SAT;
        end
        return sum;
    endfunction

    function automatic score_beat_t predict_envelope();
        score_beat_t res;
        longint unsigned scale, best, sc, best_r;
        longint best_s, shift_amt, k;
        bit first;
        scale = (ratio_scl != 0) ? 64'(ratio_scl) : 64'd1;
        best_s = 0;
        if (sh_en)
        begin
            k = longint'(shift_k);
            first = 1'b1;
            best = 0;
            for (longint s = -k; s <= k; s++)
            begin
                sc = envelope_sum(s * longint'(shift_step), scale, scale);
                if (first || sc > best)
                begin
                    best = sc;
                    best_s = s;
                    first = 1'b0;
                end
            end
        end
        shift_amt = best_s * longint'(shift_step);
        best_r = scale;
        if (ra_en)
        begin
            best_r = 0;
            first = 1'b1;
            best = 0;
            for (longint unsigned r = 64'(ratio_beg); r <= ratio_end; r++)
            begin
                sc = envelope_sum(shift_amt, r, scale);
                if (first || sc > best)
                begin
                    best = sc;
                    best_r = r;
                    first = 1'b0;
                end
            end
        end
        res.score = envelope_sum(shift_amt, best_r, scale);
        res.shift = best_s[8:0];
        res.ratio = best_r[11:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // peak driver
    int drv_gap = 0;
    always @(posedge clk)
    begin
        peak_beat_t pb;
        if (!rst_n)
            peak_in.valid <= 1'b0;
        else if (!peak_in.valid || peak_in.ready)
        begin
            if (drv_gap > 0)
            begin
                drv_gap--;
                peak_in.valid <= 1'b0;
            end
            else if (pending_peaks.size() > 0)
            begin
                pb = pending_peaks.pop_front();
                peak_in.theo_mz <= pb.theo_mz;
                peak_in.theo_level <= pb.theo_lvl;
                peak_in.real_mz <= pb.real_mz;
                peak_in.obs_level <= pb.obs_lvl;
                peak_in.real_present <= pb.present;
                peak_in.last_peak <= pb.last;
                peak_in.valid <= 1'b1;
                drv_gap = burst ? 0 : $urandom_range(0, 7);
            end
            else
                peak_in.valid <= 1'b0;
        end
    end

    // accepted peak beats feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && peak_in.valid && peak_in.ready)
        begin
            if (st_count < iems_pkg::MAX_PEAKS)
            begin
                st_theo_mz[st_count] = peak_in.theo_mz;
                st_theo_lvl[st_count] = peak_in.theo_level;
                st_real_mz[st_count] = peak_in.real_mz;
                st_obs_lvl[st_count] = peak_in.obs_level;
                st_present[st_count] = peak_in.real_present;
                st_count++;
            end
            if (peak_in.last_peak)
            begin
                expected_scores.push_back(predict_envelope());
                st_count = 0;
            end
        end
    end

    // score sink and checker
    int sink_wait = 0;
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge clk)
    begin
        score_beat_t want;
        if (rst_n && score_out.valid && score_out.ready)
        begin
            if (expected_scores.size() == 0)
                report_mismatch("unexpected score beat", 64'(score_out.match_score), 0);
            else
            begin
                want = expected_scores.pop_front();
                if (score_out.match_score !== want.score)
                    report_mismatch("match_score", 64'(score_out.match_score),
                                    64'(want.score));
                if (score_out.chosen_shift !== want.shift)
                    report_mismatch("chosen_shift", 64'(score_out.chosen_shift),
                                    64'(want.shift));
                if (score_out.chosen_ratio !== want.ratio)
                    report_mismatch("chosen_ratio", 64'(score_out.chosen_ratio),
                                    64'(want.ratio));
            end
            sink_wait = burst ? 0 : $urandom_range(0, 7);
        end
        if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_left = 40000;
        end
        if (!rst_n)
            score_out.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            score_out.ready <= 1'b0;
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            score_out.ready <= 1'b0;
        end
        else
            score_out.ready <= 1'b1;
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_peaks.size() != 0 || peak_in.valid || expected_scores.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [iems_pkg::CFG_IDX_W-1:0] idx, bit [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            iems_pkg::REG_SHIFT_EN:   sh_en = val[0];
            iems_pkg::REG_RATIO_EN:   ra_en = val[0];
            iems_pkg::REG_TOLERANCE:  tol = val;
            iems_pkg::REG_SHIFT_K:    shift_k = val[7:0];
            iems_pkg::REG_SHIFT_STEP: shift_step = val[15:0];
            iems_pkg::REG_RATIO_BEG:  ratio_beg = val[11:0];
            iems_pkg::REG_RATIO_END:  ratio_end = val[11:0];
            iems_pkg::REG_RATIO_SCL:  ratio_scl = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(bit se, bit re, bit [23:0] tl, bit [7:0] k, bit [15:0] st,
                            bit [11:0] rb, bit [11:0] rend, bit [11:0] rs);
        wait_idle();
        write_reg(iems_pkg::REG_SHIFT_EN, 24'(se));
        write_reg(iems_pkg::REG_RATIO_EN, 24'(re));
        write_reg(iems_pkg::REG_TOLERANCE, tl);
        write_reg(iems_pkg::REG_SHIFT_K, 24'(k));
        write_reg(iems_pkg::REG_SHIFT_STEP, 24'(st));
        write_reg(iems_pkg::REG_RATIO_BEG, 24'(rb));
        write_reg(iems_pkg::REG_RATIO_END, 24'(rend));
        write_reg(iems_pkg::REG_RATIO_SCL, 24'(rs));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_peak(bit [31:0] tm, bit [31:0] ti, bit [31:0] rm, bit [31:0] ri,
                             bit pr, bit lst);
        peak_beat_t pb;
        pb.theo_mz = tm;
        pb.theo_lvl = ti;
        pb.real_mz = rm;
        pb.obs_lvl = ri;
        pb.present = pr;
        pb.last = lst;
        pending_peaks.push_back(pb);
    endtask

    // random envelope of n peaks, mostly near-matching pairs
    task automatic push_envelope(int n, int present_pct);
        bit [31:0] tm, ti, rm, ri;
        for (int i = 0; i < n; i++)
        begin
            tm = $urandom();
            ti = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100000);
            case ($urandom_range(0, 9))
                0:       rm = $urandom();
                1:       rm = tm;
                default: rm = tm + $urandom_range(0, 4000) - 2000;
            endcase
            case ($urandom_range(0, 9))
                0:       ri = 0;
                1:       ri = $urandom();
                2, 3:    ri = ti;
                default: ri = ti + $urandom_range(0, 2000) - 1000;
            endcase
            push_peak(tm, ti, rm, ri, $urandom_range(0, 99) < present_pct, i == n - 1);
        end
    endtask

    initial
    begin
        int nenv;
        bit [11:0] rb, rs;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, field extremes
        burst = 1'b1;
        push_peak(32'd1000000, 32'd5000, 32'd1000000, 32'd5000, 1'b1, 1'b1);
        push_peak(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0);
        push_peak(32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
        push_peak(32'd70000, 32'd900, 32'd70655, 32'd0, 1'b1, 1'b0);
        push_peak(32'd80000, 32'd900, 32'd80100, 32'd300, 1'b0, 1'b0);
        push_peak(32'd90000, 32'd1, 32'd90000, 32'hFFFFFFFF, 1'b1, 1'b1);
        push_peak(32'd0, 32'd40000, 32'hFFFFFFFF, 32'd100, 1'b1, 1'b1);
        burst = 1'b0;

        // zero tolerance, zero ratio scale with ratio search off
        set_regs(1'b1, 1'b0, 24'd0, 8'd1, 16'd655, 12'd10, 12'd12, 12'd0);
        push_envelope(3, 100);
        // zero scale with ratio search on, empty ratio range
        set_regs(1'b0, 1'b1, 24'd2000, 8'd0, 16'd1, 12'd30, 12'd29, 12'd0);
        push_envelope(2, 100);
        set_regs(1'b0, 1'b1, 24'd2000, 8'd0, 16'd1, 12'd4095, 12'd0, 12'd4095);
        push_envelope(2, 100);
        // both searches off, maximal tolerance, store overflow
        set_regs(1'b0, 1'b0, 24'hFFFFFF, 8'd0, 16'hFFFF, 12'd0, 12'd0, 12'd1);
        push_envelope(34, 100);
        push_envelope(33, 50);
        push_envelope(1, 100);
        // widest shift search, single peak
        set_regs(1'b1, 1'b0, 24'd100000, 8'd255, 16'hFFFF, 12'd0, 12'd0, 12'd100);
        push_peak(32'h80000000, 32'd5000, 32'h80000000 + 32'd3 * 32'hFFFF, 32'd5000,
                  1'b1, 1'b1);
        // widest ratio range over absent peaks
        set_regs(1'b0, 1'b1, 24'd1311, 8'd0, 16'd1, 12'd0, 12'd4095, 12'd4095);
        push_envelope(2, 0);

        // back-pressure: hold the score side while envelopes keep coming
        set_regs(1'b1, 1'b1, 24'd1500, 8'd1, 16'd500, 12'd99, 12'd101, 12'd100);
        burst = 1'b1;
        hold_ask++;
        for (int e = 0; e < 8; e++)
            push_envelope(2, 100);
        wait_idle();
        burst = 1'b0;

        // random phases
        for (int ph = 0; ph < 14; ph++)
        begin
            rs = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
            case ($urandom_range(0, 2))
                0:       rb = 12'($urandom_range(0, 4095));
                default: rb = (rs > 12'd2) ? rs - 12'd2 : 12'd0;
            endcase
            set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                 : 24'($urandom_range(1, 4000)),
                     8'($urandom_range(0, 2)), 16'($urandom_range(1, 65535)), rb,
                     ($urandom_range(0, 7) == 0) ? ((rb > 12'd0) ? rb - 12'd1 : 12'd0)
                         : ((rb > 12'd4092) ? 12'd4095 : rb + 12'($urandom_range(0, 3))),
                     rs);
            burst = ($urandom_range(0, 3) == 0);
            nenv = $urandom_range(20, 30);
            for (int e = 0; e < nenv; e++)
                push_envelope($urandom_range(1, 6), 75);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
